FILE: hw/rtl/crrq_pkg.sv
`default_nettype none

package crrq_pkg;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_SERVICE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_FINISH = 3'b100
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/crrq_cell.sv
`default_nettype none

module crrq_cell #(
  parameter int ID_BITS     = 8,
  parameter int VOLUME_BITS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   shift,
  input  wire logic [ID_BITS-1:0]     d_id,
  input  wire logic [VOLUME_BITS-1:0] d_vol,
  output logic      [ID_BITS-1:0]     q_id,
  output logic      [VOLUME_BITS-1:0] q_vol
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q_id  <= d_id;
      q_vol <= d_vol;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/coalescing_request_ring_queue_unit.sv
// Sequence: a service transaction goes through S_FINISH to its registered result,
// an enqueue transaction through S_SEARCH and S_FINISH; a stalled output holds S_FINISH.
// Throughput: one item at a time; the enqueue search rotates the cell ring through all
// QUEUE_SLOTS cells, one cell past the compare point per cycle.
// Reset: synchronous, clears the internal pending count, control state and output
// valid; the entry cells are not cleared.
`default_nettype none

module coalescing_request_ring_queue_unit
  import crrq_pkg::*;
#(
  parameter int QUEUE_SLOTS = 16,
  parameter int ID_BITS     = 8,
  parameter int VOLUME_BITS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   operation,
  input  wire logic [ID_BITS-1:0]     sound_id,
  input  wire logic [VOLUME_BITS-1:0] volume,
  input  wire logic                   channel_free,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        dispatched,
  output logic      [ID_BITS-1:0]     out_sound_id,
  output logic      [VOLUME_BITS-1:0] out_volume,
  output logic                        merged,
  output logic                        dropped,
  output logic      [3:0]             pending_count
);

  localparam int CW = $clog2(QUEUE_SLOTS);
  localparam logic [CW-1:0] LAST = CW'(QUEUE_SLOTS - 1);

  state_t state;
  logic [CW-1:0] count;
  logic [CW-1:0] step;
  logic          merged_r;
  logic [ID_BITS-1:0]     req_id;
  logic [VOLUME_BITS-1:0] req_vol;

  logic                   res_disp, res_merged, res_dropped;
  logic [ID_BITS-1:0]     res_id;
  logic [VOLUME_BITS-1:0] res_vol;
  logic [CW-1:0]          res_count;

  logic [ID_BITS-1:0]     id_q  [QUEUE_SLOTS];
  logic [VOLUME_BITS-1:0] vol_q [QUEUE_SLOTS];
  logic [ID_BITS-1:0]     feed_id;
  logic [VOLUME_BITS-1:0] feed_vol;

  logic accept, pop, rotate, searching, hit, ins, merged_f, full, out_free;
  logic [CW+3:0] cnt_ext;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign pop       = accept && (operation == OP_SERVICE) && (count != '0) && channel_free;
  assign searching = (state == S_SEARCH);
  assign full      = (count == LAST);
  assign hit       = searching && (step < count) && !merged_r && (id_q[0] == req_id);
  assign ins       = searching && (step == count) && !merged_r && !full;
  assign merged_f  = merged_r || hit;
  assign rotate    = searching || pop;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    feed_id  = id_q[0];
    feed_vol = vol_q[0];
    if (ins) begin
      feed_id  = req_id;
      feed_vol = req_vol;
    end else if (hit && (req_vol > vol_q[0])) begin
      feed_vol = req_vol;
    end
  end

  for (genvar j = 0; j < QUEUE_SLOTS; j++) begin : g_cell
    if (j == QUEUE_SLOTS - 1) begin : g_tail
      crrq_cell #(.ID_BITS(ID_BITS), .VOLUME_BITS(VOLUME_BITS)) u_cell (
        .clk   (clk),
        .shift (rotate),
        .d_id  (feed_id),
        .d_vol (feed_vol),
        .q_id  (id_q[j]),
        .q_vol (vol_q[j])
      );
    end else begin : g_body
      crrq_cell #(.ID_BITS(ID_BITS), .VOLUME_BITS(VOLUME_BITS)) u_cell (
        .clk   (clk),
        .shift (rotate),
        .d_id  (id_q[j+1]),
        .d_vol (vol_q[j+1]),
        .q_id  (id_q[j]),
        .q_vol (vol_q[j])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      step      <= '0;
      merged_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (out_valid && !out_stall) out_valid <= 1'b0;
          if (accept) begin
            req_id      <= sound_id;
            req_vol     <= volume;
            step        <= '0;
            merged_r    <= 1'b0;
            res_merged  <= 1'b0;
            res_dropped <= 1'b0;
            if (operation == OP_SERVICE) begin
              res_disp  <= pop;
              res_id    <= pop ? id_q[0] : '0;
              res_vol   <= pop ? vol_q[0] : '0;
              res_count <= pop ? count - 1'b1 : count;
              if (pop) count <= count - 1'b1;
              state <= S_FINISH;
            end else begin
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (out_valid && !out_stall) out_valid <= 1'b0;
          if (hit) merged_r <= 1'b1;
          step <= step + 1'b1;
          if (step == LAST) begin
            res_disp    <= 1'b0;
            res_id      <= '0;
            res_vol     <= '0;
            res_merged  <= merged_f;
            res_dropped <= !merged_f && full;
            if (!merged_f && !full) begin
              count     <= count + 1'b1;
              res_count <= count + 1'b1;
            end else begin
              res_count <= count;
            end
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            dispatched    <= res_disp;
            out_sound_id  <= res_id;
            out_volume    <= res_vol;
            merged        <= res_merged;
            dropped       <= res_dropped;
            pending_count <= cnt_ext[3:0];
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cnt_ext = {4'b0000, res_count};

endmodule

`default_nettype wire

FILE: hw/rtl/crrq_checker.sv
`default_nettype none

module crrq_checker
  import crrq_pkg::*;
#(
  parameter int ID_BITS     = 8,
  parameter int VOLUME_BITS = 8
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire logic                   operation,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic                   dispatched,
  input wire logic [ID_BITS-1:0]     out_sound_id,
  input wire logic [VOLUME_BITS-1:0] out_volume,
  input wire logic                   merged,
  input wire logic                   dropped
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(dispatched) && $stable(out_sound_id)
      && $stable(out_volume) && $stable(merged) && $stable(dropped))
    else $error("stalled result changed");

  // one transaction in flight
  a_single: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted while busy");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(merged && dropped) && !(dispatched && (merged || dropped)))
    else $error("conflicting result flags");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !dispatched |-> (out_sound_id == '0) && (out_volume == '0))
    else $error("payload not zero without dispatch");

  // hold a stalled transaction
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(operation))
    else $error("stalled transaction changed");

endmodule

bind coalescing_request_ring_queue_unit crrq_checker #(
  .ID_BITS     (ID_BITS),
  .VOLUME_BITS (VOLUME_BITS)
) u_crrq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .operation    (operation),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .dispatched   (dispatched),
  .out_sound_id (out_sound_id),
  .out_volume   (out_volume),
  .merged       (merged),
  .dropped      (dropped)
);

`default_nettype wire
